/* hw/rtl/wrff_pkg.sv */
// Shared types, constants and helpers for the receive frame filter.
package wrff_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 2346;
    localparam logic [11:0] MAX_FRAME_LEN   = 12'(MAX_FRAME_BYTES);
    localparam logic [11:0] FCS_LEN         = 12'd4;
    localparam logic [11:0] MIN_ACK_LEN     = 12'd10;
    localparam logic [11:0] MIN_FRAME_LEN   = 12'(4 + 24);
    localparam logic [11:0] IE_FIRST_POS    = 12'(24 + 12);

    localparam logic [7:0] FC_ACK        = 8'hD4;
    localparam logic [7:0] FC_ACK_MASK   = 8'hFC;
    localparam logic [1:0] FTYPE_MGMT    = 2'd0;
    localparam logic [1:0] FTYPE_CTRL    = 2'd1;
    localparam logic [1:0] FTYPE_DATA    = 2'd2;
    localparam logic [3:0] SUB_PROBE_REQ = 4'd4;
    localparam logic [3:0] SUB_PROBE_RSP = 4'd5;
    localparam logic [3:0] SUB_BEACON    = 4'd8;

    localparam logic [1:0] KIND_MGMT  = 2'd0;
    localparam logic [1:0] KIND_CTRL  = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    localparam logic CFG_OWN_ADDR   = 1'b0;
    localparam logic CFG_WATCH_ADDR = 1'b1;

    typedef enum logic [2:0] {
        V_OTHER_KIND   = 3'd0,
        V_TOO_SHORT    = 3'd1,
        V_FILTERED     = 3'd2,
        V_FORWARD      = 3'd3,
        V_ACK_TO_US    = 3'd4,
        V_CTRL_IGNORED = 3'd5
    } verdict_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [1:0]  packet_kind;
        logic [11:0] signal_length;
    } in_item_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [11:0] forward_length;
        logic [31:0] frames_counted;
        logic [31:0] acks_counted;
    } res_item_t;

    // frame state as it stands after the current beat
    typedef struct packed {
        logic [7:0] frame_ctrl;
        logic [5:0] match_flags;
        logic       vendor_found;
    } frame_sum_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [11:0] forward_length;
        logic        frame_hit;
        logic        ack_hit;
    } judge_t;

    // length without FCS, capped at the maximum MPDU
    function automatic logic [11:0] body_length(input logic [11:0] sig);
        logic [11:0] len;
        len = (sig >= FCS_LEN) ? (sig - FCS_LEN) : 12'd0;
        return (len > MAX_FRAME_LEN) ? MAX_FRAME_LEN : len;
    endfunction

endpackage

/* hw/rtl/wifi_rx_frame_filter.sv */
// Top level of the 802.11 receive frame filter.
// Takes one frame byte per clock on s_ unless a last byte is held back, and gives one
// verdict per frame on m_, carrying the FCS-stripped length and the running frame and
// ACK counters. Each byte is registered at the input and judged from that register; a
// last byte's verdict is registered into the result slot only while the slot is free or
// being drained, and otherwise the last byte waits in the input register while the
// previous verdict is unread. Own and watch addresses are written on cfg_ (index 0 own,
// 1 watch); the user must write them only while no frame is in flight, the block itself does not enforce this.
module wifi_rx_frame_filter
    import wrff_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output res_item_t   m_payload,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [47:0] cfg_data
);

    logic [47:0] own_addr_reg;
    logic [47:0] watch_addr_reg;
    logic        in_valid_reg;
    in_item_t    in_reg;
    logic        in_fire;
    logic        res_load;
    logic        m_valid_reg;
    res_item_t   m_payload_reg;
    logic [31:0] frm_cnt_reg, frm_cnt_next;
    logic [31:0] ack_cnt_reg, ack_cnt_next;
    frame_sum_t  sum;
    judge_t      judge;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_addr_reg   <= 48'd0;
            watch_addr_reg <= 48'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_OWN_ADDR:   own_addr_reg   <= cfg_data;
                CFG_WATCH_ADDR: watch_addr_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // a last beat moves on only when the result slot is free or being drained
    assign in_fire  = in_valid_reg && (!in_reg.last_byte || !m_valid_reg || m_ready);
    assign res_load = in_fire && in_reg.last_byte;
    assign s_ready  = !in_valid_reg || in_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_payload;
        end
    end

    wrff_frame_track u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_fire  (in_fire),
        .beat       (in_reg),
        .own_addr   (own_addr_reg),
        .watch_addr (watch_addr_reg),
        .sum        (sum)
    );

    wrff_judge u_judge (
        .sum      (sum),
        .kind     (in_reg.packet_kind),
        .sig_len  (in_reg.signal_length),
        .watch_on (watch_addr_reg != 48'd0),
        .judge    (judge)
    );

    assign frm_cnt_next = frm_cnt_reg + {31'd0, judge.frame_hit};
    assign ack_cnt_next = ack_cnt_reg + {31'd0, judge.ack_hit};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frm_cnt_reg <= 32'd0;
            ack_cnt_reg <= 32'd0;
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            frm_cnt_reg <= frm_cnt_next;
            ack_cnt_reg <= ack_cnt_next;
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_payload_reg.verdict        <= judge.verdict;
            m_payload_reg.forward_length <= judge.forward_length;
            m_payload_reg.frames_counted <= frm_cnt_next;
            m_payload_reg.acks_counted   <= ack_cnt_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef SYNTHESIS
    a_ack_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_load && judge.verdict == V_ACK_TO_US) |=> ack_cnt_reg == $past(ack_cnt_reg) + 32'd1)
        else $error("ack verdict without counter step");
    a_len_only_judged: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.forward_length != 12'd0) |->
        (m_payload.verdict == V_FORWARD || m_payload.verdict == V_FILTERED))
        else $error("forward length on a frame that was not judged");
    a_cnt_only_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !res_load |=> $stable(frm_cnt_reg) && $stable(ack_cnt_reg))
        else $error("counter moved without a result");
`endif

endmodule

/* hw/rtl/wrff_frame_track.sv */
// Per-byte frame tracking: position, frame control, address match flags, element walk.
module wrff_frame_track
    import wrff_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        beat_fire,
    input  in_item_t    beat,
    input  logic [47:0] own_addr,
    input  logic [47:0] watch_addr,
    output frame_sum_t  sum
);

    typedef enum logic [5:0] {
        PH_TAG  = 6'b000001,
        PH_SIZE = 6'b000010,
        PH_OUI0 = 6'b000100,
        PH_OUI1 = 6'b001000,
        PH_OUI2 = 6'b010000,
        PH_SKIP = 6'b100000
    } walk_phase_t;

    typedef enum logic [2:0] {
        WR_BUSY  = 3'b001,
        WR_FOUND = 3'b010,
        WR_MISS  = 3'b100
    } walk_res_t;

    localparam logic [7:0] IE_VENDOR = 8'd221;
    localparam logic [7:0] OUI_B0    = 8'h00;
    localparam logic [7:0] OUI_B1    = 8'h1F;
    localparam logic [7:0] OUI_B2    = 8'h32;
    localparam logic [11:0] POS_SAT  = 12'hFFF;

    logic [11:0] pos_reg, pos_next;
    logic [7:0]  fc_reg, fc_next;
    logic [11:0] ie_start_reg, ie_start_next;
    walk_phase_t phase_reg, phase_next;
    logic [7:0]  tag_reg, tag_next;
    walk_res_t   wres_reg, wres_next;
    logic [5:0]  flags_reg, flags_next;

    logic [11:0] lim;
    logic [12:0] tag_end;
    logic [12:0] elem_end;
    logic [11:0] addr_off;
    logic [1:0]  addr_k;
    logic [2:0]  addr_i;
    logic [5:0]  flags_fin;

    always_comb begin
        pos_next      = pos_reg;
        fc_next       = fc_reg;
        ie_start_next = ie_start_reg;
        phase_next    = phase_reg;
        tag_next      = tag_reg;
        wres_next     = wres_reg;
        flags_next    = flags_reg;
        lim           = body_length(beat.signal_length);
        tag_end       = {1'b0, pos_reg} + 13'd2;
        elem_end      = {1'b0, pos_reg} + 13'd1 + {5'd0, beat.data_byte};
        addr_off      = 12'd0;
        addr_k        = 2'd0;

        // address bytes 4..21: three 6-byte addresses
        if (pos_reg < 12'd10) begin
            addr_off = pos_reg - 12'd4;
            addr_k   = 2'd0;
        end else if (pos_reg < 12'd16) begin
            addr_off = pos_reg - 12'd10;
            addr_k   = 2'd1;
        end else begin
            addr_off = pos_reg - 12'd16;
            addr_k   = 2'd2;
        end
        addr_i = addr_off[2:0];

        if (pos_reg != POS_SAT) begin
            if (pos_reg == 12'd0) begin
                fc_next = beat.data_byte;
            end
            if (pos_reg >= 12'd4 && pos_reg < 12'd22) begin
                if (beat.data_byte != own_addr[8*addr_i +: 8]) begin
                    flags_next[addr_k] = 1'b0;
                end
                if (beat.data_byte != watch_addr[8*addr_i +: 8]) begin
                    flags_next[3'd3 + {1'b0, addr_k}] = 1'b0;
                end
            end
            if (wres_reg == WR_BUSY && pos_reg < lim) begin
                if (pos_reg == ie_start_reg) begin
                    if (tag_end > {1'b0, lim}) begin
                        wres_next = WR_MISS;
                    end else begin
                        tag_next   = beat.data_byte;
                        phase_next = PH_SIZE;
                    end
                end else begin
                    unique case (phase_reg)
                        PH_SIZE: begin
                            if (elem_end > {1'b0, lim}) begin
                                wres_next = WR_MISS;
                            end else begin
                                ie_start_next = elem_end[11:0];
                                phase_next = (tag_reg == IE_VENDOR && beat.data_byte >= 8'd4)
                                           ? PH_OUI0 : PH_SKIP;
                            end
                        end
                        PH_OUI0: begin
                            phase_next = (beat.data_byte == OUI_B0) ? PH_OUI1 : PH_SKIP;
                        end
                        PH_OUI1: begin
                            phase_next = (beat.data_byte == OUI_B1) ? PH_OUI2 : PH_SKIP;
                        end
                        PH_OUI2: begin
                            if (beat.data_byte == OUI_B2) begin
                                wres_next = WR_FOUND;
                            end else begin
                                phase_next = PH_SKIP;
                            end
                        end
                        PH_TAG: begin
                        end
                        PH_SKIP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pos_next = pos_reg + 12'd1;
        end

        // addresses that did not fully arrive never match
        flags_fin = flags_next;
        if (pos_next < 12'd10) flags_fin = flags_fin & 6'b110110;
        if (pos_next < 12'd16) flags_fin = flags_fin & 6'b101101;
        if (pos_next < 12'd22) flags_fin = flags_fin & 6'b011011;
    end

    assign sum.frame_ctrl   = fc_next;
    assign sum.match_flags  = flags_fin;
    assign sum.vendor_found = (wres_next == WR_FOUND);

    always_ff @(posedge aclk) begin
        if (!aresetn || (beat_fire && beat.last_byte)) begin
            pos_reg      <= 12'd0;
            fc_reg       <= 8'd0;
            ie_start_reg <= IE_FIRST_POS;
            phase_reg    <= PH_TAG;
            tag_reg      <= 8'd0;
            wres_reg     <= WR_BUSY;
            flags_reg    <= 6'h3F;
        end else if (beat_fire) begin
            pos_reg      <= pos_next;
            fc_reg       <= fc_next;
            ie_start_reg <= ie_start_next;
            phase_reg    <= phase_next;
            tag_reg      <= tag_next;
            wres_reg     <= wres_next;
            flags_reg    <= flags_next;
        end
    end

endmodule

/* hw/rtl/wrff_judge.sv */
// End-of-frame decision: verdict, forwarded length and counter increments.
module wrff_judge
    import wrff_pkg::*;
(
    input  frame_sum_t  sum,
    input  logic [1:0]  kind,
    input  logic [11:0] sig_len,
    input  logic        watch_on,
    output judge_t      judge
);

    logic [1:0] ftype;
    logic [3:0] sub;

    assign ftype = sum.frame_ctrl[3:2];
    assign sub   = sum.frame_ctrl[7:4];

    always_comb begin
        judge.verdict        = V_OTHER_KIND;
        judge.forward_length = 12'd0;
        judge.frame_hit      = 1'b0;
        judge.ack_hit        = 1'b0;
        unique case (kind) inside
            KIND_CTRL: begin
                if (sig_len >= MIN_ACK_LEN && (sum.frame_ctrl & FC_ACK_MASK) == FC_ACK
                    && sum.match_flags[0]) begin
                    judge.ack_hit = 1'b1;
                    judge.verdict = V_ACK_TO_US;
                end else begin
                    judge.verdict = V_CTRL_IGNORED;
                end
            end
            KIND_MGMT, KIND_DATA: begin
                judge.frame_hit = 1'b1;
                if (sig_len < MIN_FRAME_LEN) begin
                    judge.verdict = V_TOO_SHORT;
                end else begin
                    judge.forward_length = body_length(sig_len);
                    if (ftype == FTYPE_MGMT && sub == SUB_BEACON) begin
                        judge.verdict = sum.vendor_found ? V_FORWARD : V_FILTERED;
                    end else if (ftype == FTYPE_MGMT
                                 && (sub == SUB_PROBE_REQ || sub == SUB_PROBE_RSP)) begin
                        judge.verdict = V_FILTERED;
                    end else if (ftype == FTYPE_CTRL) begin
                        judge.verdict = V_FILTERED;
                    end else if (sum.match_flags[2:0] != 3'd0
                                 || (watch_on && sum.match_flags[5:3] != 3'd0)) begin
                        judge.verdict = V_FORWARD;
                    end else begin
                        judge.verdict = V_FILTERED;
                    end
                end
            end
            KIND_OTHER: begin
            end
            default: begin
            end
        endcase
    end

endmodule

/* bench/tb_wifi_rx_frame_filter.sv */
// Self-checking testbench for the 802.11 receive frame filter: directed and random frames.
`timescale 1ns / 100ps

module tb_wifi_rx_frame_filter
    import wrff_pkg::*;
;

    localparam logic [7:0]  VENDOR_TAG     = 8'd221;
    localparam logic [23:0] VENDOR_OUI     = 24'h001F32;
    localparam int          FCS_BYTES      = 4;
    localparam int          MIN_ACK_SIG    = 10;
    localparam int          MIN_FRAME_SIG  = 4 + 24;
    localparam int          FIRST_ELEM_POS = 24 + 12;
    localparam int          POS_LIMIT      = 4095;
    localparam int          DRAIN_CYCLES   = 4;
    localparam int          PHASE_BYTES    = 30;
    localparam int          CYCLE_LIMIT    = 40000;

    typedef enum int {
        ELEM_TAG, ELEM_SIZE, ELEM_OUI0, ELEM_OUI1, ELEM_OUI2, ELEM_SKIP
    } elem_phase_t;
    typedef enum int {WALK_BUSY, WALK_FOUND, WALK_MISS} walk_t;

    // Mirror of the filter: per-frame parse state, counters and the verdicts still owed.
    class frame_judge;
        res_item_t   verdicts_due[$];
        int unsigned errors;
        logic [47:0] own_mac;
        logic [47:0] watch_mac;
        int          byte_pos;
        int          elem_next;
        logic [7:0]  fc_low;
        logic [7:0]  elem_tag;
        elem_phase_t elem_phase;
        walk_t       walk;
        logic [5:0]  addr_hits;
        logic [31:0] frames_seen;
        logic [31:0] acks_seen;

        function new();
            errors      = 0;
            own_mac     = '0;
            watch_mac   = '0;
            frames_seen = '0;
            acks_seen   = '0;
            restart();
        endfunction

        function void restart();
            byte_pos   = 0;
            fc_low     = '0;
            elem_next  = FIRST_ELEM_POS;
            elem_phase = ELEM_TAG;
            elem_tag   = '0;
            walk       = WALK_BUSY;
            addr_hits  = '1;
        endfunction

        function void set_reg(logic idx, logic [47:0] val);
            if (idx == CFG_OWN_ADDR) own_mac = val;
            else watch_mac = val;
        endfunction

        function int body_len(logic [11:0] sig);
            int len;
            len = (sig >= FCS_BYTES) ? int'(sig) - FCS_BYTES : 0;
            return (len > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : len;
        endfunction

        // information element walk, looking for the vendor element with our OUI
        function void walk_step(int p, logic [7:0] b, int lim);
            int idx;
            if (walk != WALK_BUSY || p >= lim) return;
            if (p == elem_next) begin
                if (p + 2 > lim) begin
                    walk = WALK_MISS;
                    return;
                end
                elem_tag   = b;
                elem_phase = ELEM_SIZE;
            end else if (elem_phase == ELEM_SIZE) begin
                if (p + 1 + int'(b) > lim) begin
                    walk = WALK_MISS;
                    return;
                end
                elem_next = p + 1 + int'(b);
                if (elem_tag == VENDOR_TAG && b >= 4) elem_phase = ELEM_OUI0;
                else elem_phase = ELEM_SKIP;
            end else if (elem_phase >= ELEM_OUI0 && elem_phase <= ELEM_OUI2) begin
                idx = elem_phase - ELEM_OUI0;
                if (b != VENDOR_OUI[23 - 8*idx -: 8]) elem_phase = ELEM_SKIP;
                else if (elem_phase == ELEM_OUI2) walk = WALK_FOUND;
                else elem_phase = elem_phase_t'(elem_phase + 1);
            end
        endfunction

        function void note_byte(in_item_t beat);
            int         k;
            int         j;
            logic [1:0] ftype;
            logic [3:0] sub;
            res_item_t  r;
            if (byte_pos < POS_LIMIT) begin
                if (byte_pos == 0) fc_low = beat.data_byte;
                if (byte_pos >= 4 && byte_pos < 22) begin
                    k = (byte_pos - 4) / 6;
                    j = (byte_pos - 4) % 6;
                    if (beat.data_byte != own_mac[8*j +: 8]) addr_hits[k] = 1'b0;
                    if (beat.data_byte != watch_mac[8*j +: 8]) addr_hits[3+k] = 1'b0;
                end
                walk_step(byte_pos, beat.data_byte, body_len(beat.signal_length));
                byte_pos++;
            end
            if (!beat.last_byte) return;

            // an address that did not fully arrive cannot match
            for (k = 0; k < 3; k++)
                if (byte_pos < 10 + 6*k) begin
                    addr_hits[k]   = 1'b0;
                    addr_hits[3+k] = 1'b0;
                end

            r = '0;
            r.verdict = V_OTHER_KIND;
            case (beat.packet_kind)
                KIND_CTRL: begin
                    if (beat.signal_length >= MIN_ACK_SIG && (fc_low & FC_ACK_MASK) == FC_ACK
                        && addr_hits[0]) begin
                        acks_seen++;
                        r.verdict = V_ACK_TO_US;
                    end else begin
                        r.verdict = V_CTRL_IGNORED;
                    end
                end
                KIND_MGMT, KIND_DATA: begin
                    frames_seen++;
                    if (beat.signal_length < MIN_FRAME_SIG) begin
                        r.verdict = V_TOO_SHORT;
                    end else begin
                        ftype = fc_low[3:2];
                        sub   = fc_low[7:4];
                        r.forward_length = 12'(body_len(beat.signal_length));
                        if (ftype == FTYPE_MGMT && sub == SUB_BEACON) begin
                            if (walk == WALK_FOUND) r.verdict = V_FORWARD;
                            else r.verdict = V_FILTERED;
                        end else if (ftype == FTYPE_MGMT
                                     && (sub == SUB_PROBE_REQ || sub == SUB_PROBE_RSP)) begin
                            r.verdict = V_FILTERED;
                        end else if (ftype == FTYPE_CTRL) begin
                            r.verdict = V_FILTERED;
                        end else if (addr_hits[2:0] != 0
                                     || (watch_mac != 0 && addr_hits[5:3] != 0)) begin
                            r.verdict = V_FORWARD;
                        end else begin
                            r.verdict = V_FILTERED;
                        end
                    end
                end
                default: ;
            endcase
            r.frames_counted = frames_seen;
            r.acks_counted   = acks_seen;
            verdicts_due.push_back(r);
            restart();
        endfunction

        function void same(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_verdict(res_item_t got);
            res_item_t want;
            if (verdicts_due.size() == 0) begin
                $error("verdict with no frame outstanding: %0d", got.verdict);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            same("verdict", want.verdict, got.verdict);
            same("forward_length", want.forward_length, got.forward_length);
            same("frames_counted", want.frames_counted, got.frames_counted);
            same("acks_counted", want.acks_counted, got.acks_counted);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_payload = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    res_item_t   m_payload;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [47:0] cfg_data  = '0;

    frame_judge  judge = new();
    logic        idling = 1'b1;
    int          stall_left = 0;
    int unsigned cycle_count = 0;
    logic [7:0]  frame_q[$];
    logic [47:0] own_mac = '0;
    logic [47:0] watch_mac = '0;

    wifi_rx_frame_filter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: check accepted verdicts, stall in short random bursts
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) judge.check_verdict(m_payload);
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic logic [47:0] rand_mac();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic logic [47:0] pick_mac();
        case ($urandom_range(0, 5))
            0, 1:    return own_mac;
            2:       return watch_mac;
            3:       return '0;
            4:       return own_mac ^ (48'd1 << $urandom_range(0, 47));
            default: return rand_mac();
        endcase
    endfunction

    function automatic void push_random(int n);
        repeat (n) frame_q.push_back(8'($urandom));
    endfunction

    function automatic void push_mac(logic [47:0] mac);
        for (int i = 0; i < 6; i++) frame_q.push_back(mac[8*i +: 8]);
    endfunction

    // 24-byte MAC header: frame control, flags, duration, three addresses, sequence
    function automatic void begin_frame(logic [7:0] fc, logic [47:0] a1, logic [47:0] a2,
                                        logic [47:0] a3);
        frame_q.delete();
        frame_q.push_back(fc);
        push_random(3);
        push_mac(a1);
        push_mac(a2);
        push_mac(a3);
        push_random(2);
    endfunction

    function automatic void push_element(logic [7:0] tag, int size, logic [23:0] lead);
        frame_q.push_back(tag);
        frame_q.push_back(8'(size));
        for (int i = 0; i < size; i++)
            frame_q.push_back((i < 3) ? lead[23 - 8*i -: 8] : 8'($urandom));
    endfunction

    function automatic void trim(int n);
        while (frame_q.size() > n) void'(frame_q.pop_back());
    endfunction

    function automatic logic [11:0] natural_sig();
        return 12'(frame_q.size() + FCS_BYTES);
    endfunction

    task automatic push_byte(in_item_t beat);
        if (idling && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= beat;
        do @(posedge aclk); while (!s_ready);
        judge.note_byte(beat);
    endtask

    task automatic send_frame(logic [1:0] kind, logic [11:0] sig);
        in_item_t beat;
        for (int i = 0; i < frame_q.size(); i++) begin
            beat.data_byte     = frame_q[i];
            beat.last_byte     = (i == frame_q.size() - 1);
            beat.signal_length = sig;
            beat.packet_kind   = kind;
            // only the class on the last beat decides
            if (!beat.last_byte && $urandom_range(0, 9) == 0) beat.packet_kind = 2'($urandom);
            push_byte(beat);
        end
    endtask

    task automatic write_reg(logic idx, logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_OWN_ADDR) own_mac = val;
        else watch_mac = val;
        judge.set_reg(idx, val);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (judge.verdicts_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_directed();
        // ACKs: to us, all FC low bits at minimum length, one below minimum, wrong RA, RA cut short, zero length
        begin_frame(FC_ACK, own_mac, '0, '0);
        trim(10);
        send_frame(KIND_CTRL, 12'd14);
        begin_frame(FC_ACK | 8'h03, own_mac, '0, '0);
        trim(10);
        send_frame(KIND_CTRL, 12'(MIN_ACK_SIG));
        begin_frame(FC_ACK, own_mac, '0, '0);
        trim(10);
        send_frame(KIND_CTRL, 12'(MIN_ACK_SIG - 1));
        begin_frame(FC_ACK, ~own_mac, '0, '0);
        trim(10);
        send_frame(KIND_CTRL, 12'd14);
        begin_frame(FC_ACK, own_mac, '0, '0);
        trim(8);
        send_frame(KIND_CTRL, 12'd14);
        begin_frame(FC_ACK, own_mac, '0, '0);
        trim(10);
        send_frame(KIND_CTRL, 12'd0);
        // data frames matched on each address slot, one with its third address cut short, and none
        begin_frame({4'd0, FTYPE_DATA, 2'b00}, own_mac, rand_mac(), rand_mac());
        push_random(6);
        send_frame(KIND_DATA, natural_sig());
        begin_frame({4'd8, FTYPE_DATA, 2'b11}, rand_mac(), watch_mac, rand_mac());
        send_frame(KIND_DATA, natural_sig());
        begin_frame({4'd0, FTYPE_DATA, 2'b01}, rand_mac(), rand_mac(), own_mac);
        send_frame(KIND_MGMT, natural_sig());
        begin_frame({4'd0, FTYPE_DATA, 2'b00}, rand_mac(), rand_mac(), own_mac);
        trim(20);
        send_frame(KIND_DATA, 12'd40);
        begin_frame({4'd0, FTYPE_DATA, 2'b00}, rand_mac(), rand_mac(), rand_mac());
        send_frame(KIND_DATA, natural_sig());
        // length edges: just below and at the minimum, one-byte stream
        begin_frame({4'd13, FTYPE_MGMT, 2'b00}, own_mac, own_mac, own_mac);
        send_frame(KIND_MGMT, 12'(MIN_FRAME_SIG - 1));
        begin_frame({4'd13, FTYPE_MGMT, 2'b00}, own_mac, own_mac, own_mac);
        send_frame(KIND_MGMT, 12'(MIN_FRAME_SIG));
        frame_q.delete();
        frame_q.push_back(FC_ACK);
        send_frame(KIND_MGMT, 12'd3);
        // beacons: vendor OUI found, wrong OUI, short vendor element
        begin_frame({SUB_BEACON, FTYPE_MGMT, 2'b00}, '1, rand_mac(), rand_mac());
        push_random(12);
        push_element(8'd0, 5, 24'($urandom));
        push_element(VENDOR_TAG, 7, VENDOR_OUI);
        push_element(8'd1, 2, 24'($urandom));
        send_frame(KIND_MGMT, natural_sig());
        begin_frame({SUB_BEACON, FTYPE_MGMT, 2'b00}, '1, own_mac, own_mac);
        push_random(12);
        push_element(VENDOR_TAG, 6, VENDOR_OUI ^ 24'h000001);
        push_element(VENDOR_TAG, 3, VENDOR_OUI);
        send_frame(KIND_MGMT, natural_sig());
        // truncated element: size reaches past the end
        begin_frame({SUB_BEACON, FTYPE_MGMT, 2'b00}, '1, rand_mac(), rand_mac());
        push_random(12);
        push_element(VENDOR_TAG, 40, VENDOR_OUI);
        trim(FIRST_ELEM_POS + 10);
        send_frame(KIND_MGMT, natural_sig());
        // tag on the final body byte, no room for its size
        begin_frame({SUB_BEACON, FTYPE_MGMT, 2'b00}, '1, rand_mac(), rand_mac());
        push_random(12);
        push_element(8'd3, 1, 24'($urandom));
        frame_q.push_back(VENDOR_TAG);
        send_frame(KIND_MGMT, natural_sig());
        // stream ends mid-walk
        begin_frame({SUB_BEACON, FTYPE_MGMT, 2'b00}, '1, rand_mac(), rand_mac());
        push_random(12);
        push_element(VENDOR_TAG, 10, VENDOR_OUI);
        trim(FIRST_ELEM_POS + 3);
        send_frame(KIND_MGMT, 12'd60);
        // longest signal length: length capped
        begin_frame({SUB_BEACON, FTYPE_MGMT, 2'b00}, '1, rand_mac(), rand_mac());
        push_random(12);
        push_element(VENDOR_TAG, 4, VENDOR_OUI);
        send_frame(KIND_MGMT, 12'hFFF);
        // probes and control-typed frames are dropped even when addressed to us
        begin_frame({SUB_PROBE_REQ, FTYPE_MGMT, 2'b00}, own_mac, own_mac, own_mac);
        send_frame(KIND_MGMT, natural_sig());
        begin_frame({SUB_PROBE_RSP, FTYPE_MGMT, 2'b00}, own_mac, own_mac, own_mac);
        send_frame(KIND_MGMT, natural_sig());
        begin_frame({4'd11, FTYPE_CTRL, 2'b00}, own_mac, own_mac, own_mac);
        send_frame(KIND_DATA, natural_sig());
        begin_frame({4'd0, FTYPE_DATA, 2'b00}, own_mac, own_mac, own_mac);
        send_frame(KIND_OTHER, natural_sig());
    endtask

    task automatic random_frame(output int n_bytes);
        int         cat;
        int         n;
        logic [7:0] fc;
        logic [1:0] kind;
        logic [11:0] sig;
        cat = $urandom_range(0, 99);
        if (cat < 15) begin
            fc = FC_ACK | 8'($urandom_range(0, 3));
            if ($urandom_range(0, 7) == 0) fc = 8'($urandom);
            begin_frame(fc, pick_mac(), '0, '0);
            trim(($urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : 10);
            kind = ($urandom_range(0, 9) == 0) ? 2'($urandom) : KIND_CTRL;
        end else if (cat < 40) begin
            begin_frame({4'($urandom), FTYPE_DATA, 2'($urandom)},
                        pick_mac(), pick_mac(), pick_mac());
            push_random($urandom_range(0, 30));
            if ($urandom_range(0, 5) == 0) trim($urandom_range(1, 24));
            kind = $urandom_range(0, 1) ? KIND_DATA : KIND_MGMT;
        end else if (cat < 65) begin
            begin_frame({SUB_BEACON, FTYPE_MGMT, 2'($urandom)},
                        pick_mac(), pick_mac(), pick_mac());
            push_random(12);
            n = $urandom_range(0, 4);
            repeat (n) begin
                case ($urandom_range(0, 3))
                    0: push_element(VENDOR_TAG, $urandom_range(4, 10), VENDOR_OUI);
                    1: push_element(VENDOR_TAG, $urandom_range(0, 8),
                                    VENDOR_OUI ^ (24'd1 << $urandom_range(0, 23)));
                    2: push_element(8'($urandom), $urandom_range(0, 12), 24'($urandom));
                    default: push_element(VENDOR_TAG, $urandom_range(0, 4), VENDOR_OUI);
                endcase
            end
            if ($urandom_range(0, 4) == 0) trim(frame_q.size() - $urandom_range(1, 5));
            kind = ($urandom_range(0, 9) == 0) ? 2'($urandom) : KIND_MGMT;
        end else if (cat < 75) begin
            begin_frame({4'($urandom), FTYPE_MGMT, 2'($urandom)},
                        pick_mac(), pick_mac(), pick_mac());
            push_random($urandom_range(0, 20));
            kind = KIND_MGMT;
        end else if (cat < 85) begin
            begin_frame({4'($urandom), FTYPE_CTRL, 2'($urandom)},
                        pick_mac(), pick_mac(), pick_mac());
            trim($urandom_range(1, 30));
            kind = 2'($urandom);
        end else begin
            frame_q.delete();
            push_random($urandom_range(1, 40));
            kind = 2'($urandom);
        end
        case ($urandom_range(0, 9))
            7:       sig = 12'($urandom_range(0, 4095));
            8:       sig = 12'(int'(natural_sig()) + $urandom_range(0, 6) - 3);
            9:       sig = 12'(int'(natural_sig()) + $urandom_range(1, 40));
            default: sig = natural_sig();
        endcase
        n_bytes = frame_q.size();
        send_frame(kind, sig);
    endtask

    initial begin
        int sent;
        int phase_bytes;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_reg(CFG_OWN_ADDR, rand_mac());
        write_reg(CFG_WATCH_ADDR, rand_mac());
        run_directed();
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(CFG_OWN_ADDR, '0);
                    write_reg(CFG_WATCH_ADDR, '0);
                end
                1: begin
                    write_reg(CFG_OWN_ADDR, '1);
                    write_reg(CFG_WATCH_ADDR, '1);
                end
                2: begin
                    write_reg(CFG_OWN_ADDR, rand_mac());
                    write_reg(CFG_WATCH_ADDR, '0);
                end
                4: begin
                    write_reg(CFG_OWN_ADDR, '1);
                    write_reg(CFG_WATCH_ADDR, rand_mac());
                end
                default: begin
                    write_reg(CFG_OWN_ADDR, rand_mac());
                    write_reg(CFG_WATCH_ADDR, rand_mac());
                end
            endcase
            if (ph == 5) idling = 1'b0;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                random_frame(sent);
                phase_bytes += sent;
            end
        end
        drain();
        if (judge.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/wrff_pkg.sv
hw/rtl/wrff_frame_track.sv
hw/rtl/wrff_judge.sv
hw/rtl/wifi_rx_frame_filter.sv
bench/tb_wifi_rx_frame_filter.sv
